// ===== hdl/rolling_window_checksum_top_assert.svh =====
// Assertion macros for the rolling window checksum checker.
// Expects signals clk and rst_n in the scope where the macros are used.
`ifndef ROLLING_WINDOW_CHECKSUM_TOP_ASSERT_SVH
`define ROLLING_WINDOW_CHECKSUM_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define RWC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held
`define RWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check what reset leaves behind on the cycle after it is applied
`define RWC_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rwc_pkg.sv =====
// Shared types, constants and helpers for the rolling window checksum block.
// No dependencies; imported by every module of the block but rwc_ram.
`timescale 1ns / 1ps

package rwc_pkg;

  // Sizing
  localparam int MAX_WINDOW_LOG2 = 12;
  localparam int MIN_WINDOW_LOG2 = 2;
  localparam int RING_DEPTH      = 1 << MAX_WINDOW_LOG2;
  localparam int PTR_W           = MAX_WINDOW_LOG2;
  localparam int LEN_W           = MAX_WINDOW_LOG2 + 1;
  localparam int LG_W            = $clog2(MAX_WINDOW_LOG2 + 1);
  localparam int OFF_W           = 48;
  localparam int SUM_W           = 16;
  localparam int BYTE_W          = 8;
  localparam int CSUM_W          = 2 * SUM_W;
  localparam int CFG_W           = 4;
  localparam int CFG_IDX_W       = 1;
  localparam int CMDQ_DEPTH      = 4;
  localparam int CMDQ_AW         = $clog2(CMDQ_DEPTH);
  localparam int RES_DEPTH       = 2;
  localparam int RES_AW          = $clog2(RES_DEPTH);

  localparam logic [OFF_W-1:0] OFFSET_MAX  = {OFF_W{1'b1}};
  localparam logic [CFG_W-1:0] WLOG_RESET  = CFG_W'(10);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOG2  = 1'b0,
    REG_ROLLING_MODE = 1'b1
  } cfg_reg_t;

  // One classified byte, passed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [PTR_W-1:0]  addr;
    logic              roll;       // subtract the byte leaving the window
    logic [LG_W-1:0]   lg;
    logic              clr_before; // new stream: sums start from zero
    logic              emit;
    logic              clr_after;  // sums restart after this byte
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic              last;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [CSUM_W-1:0] checksum;
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic              last;
  } res_t;

  // Clamp the window register into the supported range
  function automatic logic [LG_W-1:0] eff_log2(input logic [CFG_W-1:0] wl);
    logic [LG_W-1:0] lg;
    if (int'(wl) < MIN_WINDOW_LOG2) begin
      lg = LG_W'(MIN_WINDOW_LOG2);
    end else if (int'(wl) > MAX_WINDOW_LOG2) begin
      lg = LG_W'(MAX_WINDOW_LOG2);
    end else begin
      lg = LG_W'(wl);
    end
    return lg;
  endfunction

endpackage

// ===== hdl/rolling_window_checksum_top.sv =====
// Top level of the rolling window checksum block: configuration registers,
// front, command queue and back. Depends on rwc_pkg, rwc_front, rwc_cmd_queue and rwc_back.
`timescale 1ns / 1ps

// Rolling (rsync style) weak checksum over a byte stream. Push one byte per
// beat on the in_ queue; results come out of the out_ queue, one per window
// in block mode, one per byte offset once the window is full in rolling
// mode, and one for a short block at stream end. The block takes one byte
// every clock while in_full is low: each byte needs a single access to the
// window ring, which reads the leaving byte and writes the arriving one at
// the same slot on the same edge, and the sums are a short add chain. A
// result passes the command queue, ring read and result buffer before it is
// visible; a four-beat queue between front and back and a two-beat result
// buffer absorb stalls on the out_ side. The ring needs no clearing pass
// after reset. Write cfg_ registers only while no bytes are in flight.
module rolling_window_checksum_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rwc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [rwc_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                            in_first_byte,
  input  logic                            in_last_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [rwc_pkg::CSUM_W-1:0]      out_checksum,
  output logic [rwc_pkg::OFF_W-1:0]       out_window_start,
  output logic [rwc_pkg::LEN_W-1:0]       out_window_length,
  output logic                            out_stream_end
);
  import rwc_pkg::*;

  logic [CFG_W-1:0] wlog_r, wlog_nxt;
  logic             roll_mode_r, roll_mode_nxt;
  logic             in_accept;
  cmd_t             front_cmd, q_head;
  logic             q_valid, q_pop;
  res_t             res_head;

  // Configuration writes
  always_comb begin
    wlog_nxt      = wlog_r;
    roll_mode_nxt = roll_mode_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LOG2:  wlog_nxt      = cfg_wdata;
        REG_ROLLING_MODE: roll_mode_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlog_r      <= WLOG_RESET;
      roll_mode_r <= 1'b0;
    end else begin
      wlog_r      <= wlog_nxt;
      roll_mode_r <= roll_mode_nxt;
    end
  end

  assign in_accept = in_push && !in_full;

  rwc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .data_byte   (in_data_byte),
    .first_byte  (in_first_byte),
    .last_byte   (in_last_byte),
    .window_log2 (wlog_r),
    .rolling_mode(roll_mode_r),
    .cmd         (front_cmd)
  );

  rwc_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .push_cmd(front_cmd),
    .full    (in_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_cmd(q_head)
  );

  rwc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_head),
    .q_pop    (q_pop),
    .res_pop  (out_pop),
    .res_empty(out_empty),
    .res_head (res_head)
  );

  assign out_checksum      = res_head.checksum;
  assign out_window_start  = res_head.start;
  assign out_window_length = res_head.len;
  assign out_stream_end    = res_head.last;

endmodule

// ===== hdl/rwc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps

module rwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read before write on the same edge
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rwc_cmd_queue.sv =====
// Short queue of classified bytes between the front and back of the block.
// Depends on rwc_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps

module rwc_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rwc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output rwc_pkg::cmd_t head_cmd
);
  import rwc_pkg::*;

  cmd_t               slot_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_r, wptr_nxt;
  logic [CMDQ_AW-1:0] rptr_r, rptr_nxt;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign valid    = (cnt_r != '0);
  assign head_cmd = slot_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/rwc_front.sv =====
// Front of the checksum block: tracks fill count, ring pointer and stream
// offset, and classifies each accepted byte. Depends on rwc_pkg.
`timescale 1ns / 1ps

module rwc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [rwc_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        first_byte,
  input  logic                        last_byte,
  input  logic [rwc_pkg::CFG_W-1:0]   window_log2,
  input  logic                        rolling_mode,
  output rwc_pkg::cmd_t               cmd
);
  import rwc_pkg::*;

  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;

  logic [LG_W-1:0]  lg;
  logic [LEN_W-1:0] win;
  logic [PTR_W-1:0] mask;
  logic [PTR_W-1:0] addr;
  logic [LEN_W-1:0] fill_base, fill_new;
  logic [OFF_W-1:0] off_base, off_new;
  logic [OFF_W-1:0] len_ext;
  logic             roll, full_win, clr_after;
  logic [LEN_W-1:0] len;

  // Window geometry
  always_comb begin
    lg   = eff_log2(window_log2);
    win  = LEN_W'(1) << lg;
    mask = PTR_W'(win - 1'b1);
  end

  // Classify the byte against the current stream state
  always_comb begin
    fill_base = first_byte ? '0 : fill_r;
    off_base  = first_byte ? '0 : off_r;
    addr      = (first_byte ? '0 : ptr_r) & mask;
    off_new   = (off_base != OFFSET_MAX) ? off_base + 1'b1 : off_base;
    roll      = rolling_mode && (fill_base >= win);
    fill_new  = roll ? win : fill_base + 1'b1;
    full_win  = (fill_new >= win);
    len       = full_win ? win : fill_new;
    len_ext   = OFF_W'(len);
    clr_after = last_byte || (full_win && !rolling_mode);

    cmd.data       = data_byte;
    cmd.addr       = addr;
    cmd.roll       = roll;
    cmd.lg         = lg;
    cmd.clr_before = first_byte;
    cmd.emit       = full_win || last_byte;
    cmd.clr_after  = clr_after;
    cmd.start      = (off_new >= len_ext) ? off_new - len_ext : '0;
    cmd.len        = len;
    cmd.last       = last_byte;
  end

  // Advance stream state on each accepted beat
  always_comb begin
    ptr_nxt  = ptr_r;
    fill_nxt = fill_r;
    off_nxt  = off_r;
    if (accept) begin
      ptr_nxt  = last_byte ? '0 : ((addr + 1'b1) & mask);
      fill_nxt = clr_after ? '0 : fill_new;
      off_nxt  = last_byte ? '0 : off_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      off_r  <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
      off_r  <= off_nxt;
    end
  end

endmodule

// ===== hdl/rwc_back.sv =====
// Back of the checksum block: window ring access, the two running sums and
// the result buffer. Depends on rwc_pkg and rwc_ram.
`timescale 1ns / 1ps

module rwc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  rwc_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic          res_pop,
  output logic          res_empty,
  output rwc_pkg::res_t res_head
);
  import rwc_pkg::*;

  logic              b2_valid_r, b2_valid_nxt;
  cmd_t              b2_cmd_r;
  logic [BYTE_W-1:0] ring_rdata;

  logic [SUM_W-1:0]  bsum_r, bsum_nxt;
  logic [SUM_W-1:0]  wsum_r, wsum_nxt;
  logic [SUM_W-1:0]  bsum0, wsum0, bsum1, wsum1;
  logic [BYTE_W-1:0] drop;
  logic [SUM_W-1:0]  dshift;

  res_t              res_mem_r [RES_DEPTH];
  logic [RES_AW-1:0] res_wptr_r, res_wptr_nxt;
  logic [RES_AW-1:0] res_rptr_r, res_rptr_nxt;
  logic [RES_AW:0]   res_cnt_r, res_cnt_nxt;
  logic              res_push, res_take, res_room;
  logic              adv, retire;
  res_t              res_new;

  // Pipeline control: the sum stage retires unless it emits into a full buffer
  assign res_take  = res_pop && !res_empty;
  assign res_empty = (res_cnt_r == '0);
  assign res_room  = (res_cnt_r != (RES_AW+1)'(RES_DEPTH)) || res_take;
  assign adv       = !b2_valid_r || !b2_cmd_r.emit || res_room;
  assign q_pop     = q_valid && adv;
  assign retire    = b2_valid_r && adv;
  assign res_push  = retire && b2_cmd_r.emit;

  // Ring: fetch the leaving byte and store the new one at the same slot
  rwc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (q_pop),
    .waddr(q_cmd.addr),
    .wdata(q_cmd.data),
    .re   (q_pop),
    .raddr(q_cmd.addr),
    .rdata(ring_rdata)
  );

  always_comb begin
    b2_valid_nxt = adv ? q_pop : b2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else begin
      b2_valid_r <= b2_valid_nxt;
    end
  end

  // Hold the beat alongside its ring read
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_cmd_r <= q_cmd;
    end
  end

  // Update the byte sum and the weighted sum
  always_comb begin
    bsum0  = b2_cmd_r.clr_before ? '0 : bsum_r;
    wsum0  = b2_cmd_r.clr_before ? '0 : wsum_r;
    drop   = b2_cmd_r.roll ? ring_rdata : '0;
    dshift = SUM_W'(SUM_W'(drop) << b2_cmd_r.lg);
    bsum1  = bsum0 + SUM_W'(b2_cmd_r.data) - SUM_W'(drop);
    wsum1  = wsum0 + bsum1 - dshift;

    bsum_nxt = bsum_r;
    wsum_nxt = wsum_r;
    if (retire) begin
      bsum_nxt = b2_cmd_r.clr_after ? '0 : bsum1;
      wsum_nxt = b2_cmd_r.clr_after ? '0 : wsum1;
    end

    res_new.checksum = {wsum1, bsum1};
    res_new.start    = b2_cmd_r.start;
    res_new.len      = b2_cmd_r.len;
    res_new.last     = b2_cmd_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsum_r <= '0;
      wsum_r <= '0;
    end else begin
      bsum_r <= bsum_nxt;
      wsum_r <= wsum_nxt;
    end
  end

  // Result buffer pointers and occupancy
  always_comb begin
    res_wptr_nxt = res_push ? res_wptr_r + 1'b1 : res_wptr_r;
    res_rptr_nxt = res_take ? res_rptr_r + 1'b1 : res_rptr_r;
    res_cnt_nxt  = res_cnt_r;
    if (res_push && !res_take) begin
      res_cnt_nxt = res_cnt_r + 1'b1;
    end else if (res_take && !res_push) begin
      res_cnt_nxt = res_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wptr_r <= '0;
      res_rptr_r <= '0;
      res_cnt_r  <= '0;
    end else begin
      res_wptr_r <= res_wptr_nxt;
      res_rptr_r <= res_rptr_nxt;
      res_cnt_r  <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wptr_r] <= res_new;
    end
  end

  assign res_head = res_mem_r[res_rptr_r];

endmodule

// ===== hdl/rwc_checker.sv =====
// Port-level checks for the rolling window checksum block, bound to the top.
// Depends on rwc_pkg and rolling_window_checksum_top_assert.svh.
`timescale 1ns / 1ps
`include "rolling_window_checksum_top_assert.svh"

module rwc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic [rwc_pkg::CSUM_W-1:0]      out_checksum,
  input logic [rwc_pkg::OFF_W-1:0]       out_window_start,
  input logic [rwc_pkg::LEN_W-1:0]       out_window_length,
  input logic                            out_stream_end
);
  import rwc_pkg::*;

  // Reset leaves the result queue empty and the input queue not full
  `RWC_ASSERT_AFTER_RESET(a_reset_clear, out_empty && !in_full, "queues not clear after reset")

  // A waiting result holds until popped
  `RWC_ASSERT_NEXT(a_res_hold, !out_empty && !out_pop, !out_empty && $stable(out_checksum) && $stable(out_window_start), "result changed while stalled")

  // Every result covers at least one byte
  `RWC_ASSERT_NOW(a_len_nonzero, !out_empty, out_window_length != '0, "zero-length result")

  // Mid-stream results always cover a whole power-of-two window
  `RWC_ASSERT_NOW(a_len_window, !out_empty && !out_stream_end, $onehot(out_window_length), "short window before stream end")

endmodule

bind rolling_window_checksum_top rwc_checker u_rwc_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rolling_window_checksum_top: drives byte streams through the
// in_ queue, predicts every checksum window in-line and pops and compares the out_ beats.
// Depends on rwc_pkg and the block's RTL; reads no files.

module tb_top;
  import rwc_pkg::*;

  localparam int CLK_HALF            = 5;
  localparam int RESET_CYCLES        = 12;
  localparam int STALL_LIMIT         = 2000;  // cycles with no beat moving on either side
  localparam int SETTLE_CYCLES       = 10;    // result lags its byte through the queue and the back's registers
  localparam int SETTINGS_PER_SCHEME = 5;
  localparam int BYTES_PER_SETTING   = 30;
  localparam int MAX_REPORTS         = 10;
  localparam int LONG_WINDOW_LOG2    = 8;

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [CFG_W-1:0]     cfg_wdata         = '0;
  logic                 in_push           = 1'b0;
  logic                 in_full;
  logic [BYTE_W-1:0]    in_data_byte      = '0;
  logic                 in_first_byte     = 1'b0;
  logic                 in_last_byte      = 1'b0;
  logic                 out_empty;
  logic                 out_pop           = 1'b0;
  logic [CSUM_W-1:0]    out_checksum;
  logic [OFF_W-1:0]     out_window_start;
  logic [LEN_W-1:0]     out_window_length;
  logic                 out_stream_end;

  rolling_window_checksum_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_last_byte      (in_last_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_checksum      (out_checksum),
    .out_window_start  (out_window_start),
    .out_window_length (out_window_length),
    .out_stream_end    (out_stream_end)
  );

  // Idling percentages for the sending and popping sides
  int send_gap_pct   = 10;
  int recv_stall_pct = 69;

  int mismatches  = 0;
  int idle_cycles = 0;

  // Predicted windows still waiting for their result beat
  res_t pending_sums[$];
  res_t next_sum;

  // Checksum state as the block should hold it
  logic [CFG_W-1:0]  sum_wlog       = WLOG_RESET;
  logic              sum_rolling    = 1'b0;
  logic [SUM_W-1:0]  byte_total     = '0;
  logic [SUM_W-1:0]  weighted_total = '0;
  logic [BYTE_W-1:0] window_bytes [RING_DEPTH];
  logic [PTR_W-1:0]  window_ptr     = '0;
  int unsigned       window_fill    = 0;
  logic [OFF_W-1:0]  stream_pos     = '0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Drop all per-stream state, as at a first byte or after a last byte
  function automatic void restart_stream();
    byte_total     = '0;
    weighted_total = '0;
    window_ptr     = '0;
    window_fill    = 0;
    stream_pos     = '0;
  endfunction

  function automatic int unsigned clamped_log2(input logic [CFG_W-1:0] wl);
    int unsigned lg;
    lg = 32'(wl);
    if (lg < MIN_WINDOW_LOG2) lg = MIN_WINDOW_LOG2;
    if (lg > MAX_WINDOW_LOG2) lg = MAX_WINDOW_LOG2;
    return lg;
  endfunction

  function automatic res_t window_result(input int unsigned len, input logic at_end);
    res_t r;
    r.checksum = {weighted_total, byte_total};
    r.start    = (stream_pos >= len) ? stream_pos - len : '0;
    r.len      = LEN_W'(len);
    r.last     = at_end;
    return r;
  endfunction

  // Advance the checksum state by one byte; returns 1 when a window closes
  function automatic bit checksum_byte(input logic [BYTE_W-1:0] d, input logic first,
                                       input logic last, output res_t r);
    int unsigned       lg;
    int unsigned       win;
    logic [BYTE_W-1:0] leaving;
    logic [SUM_W-1:0]  leaving_weight;
    bit                hit;
    lg  = clamped_log2(sum_wlog);
    win = 1 << lg;
    r   = '0;
    hit = 1'b0;
    if (first) restart_stream();
    if (stream_pos != OFFSET_MAX) stream_pos = stream_pos + 1'b1;
    window_ptr = window_ptr & PTR_W'(win - 1);
    if (sum_rolling && window_fill >= win) begin
      // subtract the byte leaving the window and its weight
      leaving        = window_bytes[window_ptr];
      leaving_weight = {8'h00, leaving} << lg;
      byte_total     = byte_total + SUM_W'(d) - SUM_W'(leaving);
      weighted_total = weighted_total + byte_total - leaving_weight;
      window_fill    = win;
    end else begin
      byte_total     = byte_total + SUM_W'(d);
      weighted_total = weighted_total + byte_total;
      window_fill++;
    end
    window_bytes[window_ptr] = d;
    window_ptr = (window_ptr + 1'b1) & PTR_W'(win - 1);
    if (window_fill >= win) begin
      r   = window_result(win, last);
      hit = 1'b1;
      if (!sum_rolling) begin
        byte_total     = '0;
        weighted_total = '0;
        window_fill    = 0;
      end
    end else if (last) begin
      r   = window_result(window_fill, 1'b1);
      hit = 1'b1;
    end
    if (last) restart_stream();
    return hit;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
    end
  endtask

  // Pop side: stall at random according to the current scheme
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each popped beat with the oldest predicted window
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_sums.size() == 0) begin
        note_mismatch("unpredicted beat", '0, 64'(out_checksum));
      end else begin
        next_sum = pending_sums.pop_front();
        if (out_checksum !== next_sum.checksum)
          note_mismatch("checksum", 64'(next_sum.checksum), 64'(out_checksum));
        if (out_window_start !== next_sum.start)
          note_mismatch("window_start", 64'(next_sum.start), 64'(out_window_start));
        if (out_window_length !== next_sum.len)
          note_mismatch("window_length", 64'(next_sum.len), 64'(out_window_length));
        if (out_stream_end !== next_sum.last)
          note_mismatch("stream_end", 64'(next_sum.last), 64'(out_stream_end));
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Push one byte, with random gaps ahead of it; push stays high afterwards
  task automatic push_byte(input logic [BYTE_W-1:0] d, input logic first, input logic last);
    res_t r;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_data_byte  <= d;
    in_first_byte <= first;
    in_last_byte  <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (checksum_byte(d, first, last, r)) pending_sums.insert(pending_sums.size(), r);
  endtask

  // Hold the input until every predicted window has come out and the pipe is empty
  task automatic settle_block();
    in_push <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_LOG2) sum_wlog = val;
    else sum_rolling = val[0];
  endtask

  // One stream of random bytes closed by a last byte; noisy ones restart part way
  task automatic send_stream(input int unsigned n, input bit noisy);
    logic [BYTE_W-1:0] d;
    logic              first;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = BYTE_W'($urandom_range(255));
      endcase
      if (i == 0) first = ($urandom_range(9) != 0);
      else first = noisy && ($urandom_range(19) == 0);
      push_byte(d, first, i == n - 1);
    end
  endtask

  // Reset settings: 1 KiB blocks, so only the end-of-stream flush shows
  task automatic test_reset_defaults();
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'hA5, 1'b1, 1'b1);
    push_byte(8'h01, 1'b1, 1'b0);
    push_byte(8'h02, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b1, 1'b0);
    push_byte(8'h80, 1'b0, 1'b1);
  endtask

  // Window register outside 2..12 clamps at both ends
  task automatic test_window_clamp();
    write_reg(REG_ROLLING_MODE, CFG_W'(0));
    write_reg(REG_WINDOW_LOG2, CFG_W'(0));
    for (int i = 0; i < 6; i++) push_byte(8'hFF, i == 0, i == 5);
    write_reg(REG_WINDOW_LOG2, CFG_W'(1));
    for (int i = 0; i < 4; i++) push_byte(i[0] ? 8'hFF : 8'h00, i == 0, i == 3);
    write_reg(REG_WINDOW_LOG2, CFG_W'(13));
    push_byte(8'h5A, 1'b1, 1'b0);
    push_byte(8'hC3, 1'b0, 1'b1);
    write_reg(REG_WINDOW_LOG2, CFG_W'(15));
    push_byte(8'hFF, 1'b1, 1'b1);
  endtask

  // Shrink the window and leave rolling mode part way through one stream
  task automatic test_midstream_change();
    write_reg(REG_WINDOW_LOG2, CFG_W'(3));
    write_reg(REG_ROLLING_MODE, CFG_W'(1));
    for (int i = 0; i < 10; i++) push_byte(BYTE_W'($urandom_range(255)), i == 0, 1'b0);
    write_reg(REG_WINDOW_LOG2, CFG_W'(2));
    for (int i = 0; i < 3; i++) push_byte(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
    write_reg(REG_ROLLING_MODE, CFG_W'(0));
    for (int i = 0; i < 3; i++) push_byte(BYTE_W'($urandom_range(255)), 1'b0, i == 2);
  endtask

  // Random streams over many settings, under each idling scheme in turn
  task automatic test_random_traffic();
    logic [CFG_W-1:0] wl;
    int unsigned      win;
    int unsigned      sent;
    int unsigned      n;
    for (int scheme = 0; scheme < 3; scheme++) begin
      send_gap_pct   = (scheme == 0) ? 10 : (scheme == 1) ? 69 : 0;
      recv_stall_pct = (scheme == 0) ? 69 : (scheme == 1) ? 10 : 0;
      for (int s = 0; s < SETTINGS_PER_SCHEME; s++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: wl = CFG_W'($urandom_range(5));
          6, 7:             wl = CFG_W'($urandom_range(12, 6));
          default:          wl = CFG_W'($urandom_range(15, 13));
        endcase
        write_reg(REG_WINDOW_LOG2, wl);
        write_reg(REG_ROLLING_MODE, CFG_W'($urandom_range(1)));
        win  = 1 << clamped_log2(wl);
        sent = 0;
        // small windows see full ones; large windows only their short flush
        while (sent < BYTES_PER_SETTING) begin
          if (win <= 32) n = $urandom_range(3 * win + 2, 1);
          else n = $urandom_range(48, 1);
          send_stream(n, $urandom_range(3) == 0);
          sent += n;
        end
      end
    end
  endtask

  // Fill a long window so the ring pointer wraps, then keep rolling past it
  task automatic test_long_window();
    write_reg(REG_WINDOW_LOG2, CFG_W'(LONG_WINDOW_LOG2));
    write_reg(REG_ROLLING_MODE, CFG_W'(1));
    send_stream((1 << LONG_WINDOW_LOG2) + 6, 1'b0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_window_clamp();
    test_midstream_change();
    test_random_traffic();
    test_long_window();
    settle_block();
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
